@@ sv/sequenced_sample_ring_fifo_top_defines.svh @@
// assertion macros for the sequenced sample ring fifo
// each checks at the rising edge of clk, with rst_n low holding checks off
`ifndef SEQUENCED_SAMPLE_RING_FIFO_TOP_DEFINES_SVH
`define SEQUENCED_SAMPLE_RING_FIFO_TOP_DEFINES_SVH

`ifndef SYNTH

`define SSRF_ASSERT_SAME(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("ssrf check failed: same cycle");

`define SSRF_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("ssrf check failed: next cycle");

`else

`define SSRF_ASSERT_SAME(label, cond, conseq)

`define SSRF_ASSERT_NEXT(label, cond, conseq)

`endif

`endif

@@ sv/ssrf_pkg.sv @@
`timescale 1ns / 1ps

package ssrf_pkg;

    // ring size; the ring holds one entry fewer than this
    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int SEQ_W  = 32;
    localparam int PAY_W  = 64;
    localparam int CNT_W  = 32;
    localparam int OCC_W  = 8;
    localparam int ST_W   = 3;
    localparam int ENTRY_W = PAY_W + SEQ_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ sv/ssrf_ram.sv @@
`timescale 1ns / 1ps

module ssrf_ram #(
    parameter int W     = 96,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ssrf_ctrl.sv @@
`timescale 1ns / 1ps

module ssrf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  ssrf_pkg::dp_status_t  dp_status,
    output ssrf_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                // wait for the output register to be free
                if (dp_status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ sv/ssrf_dpath.sv @@
`timescale 1ns / 1ps

module ssrf_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssrf_pkg::ctrl_cmd_t            cmd,
    output ssrf_pkg::dp_status_t           dp_status,
    // input word
    input  logic [ssrf_pkg::OP_W-1:0]      op,
    input  logic [ssrf_pkg::SEQ_W-1:0]     seq_in,
    input  logic                           accel_ok,
    input  logic                           gyro_ok,
    input  logic [ssrf_pkg::PAY_W-1:0]     payload_in,
    // ring memory
    output logic                           mem_we,
    output logic [ssrf_pkg::PTR_W-1:0]     mem_waddr,
    output logic [ssrf_pkg::ENTRY_W-1:0]   mem_wdata,
    output logic                           mem_re,
    output logic [ssrf_pkg::PTR_W-1:0]     mem_raddr,
    input  logic [ssrf_pkg::ENTRY_W-1:0]   mem_rdata,
    // output word
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ssrf_pkg::ST_W-1:0]      status,
    output logic [ssrf_pkg::PAY_W-1:0]     payload_out,
    output logic [ssrf_pkg::SEQ_W-1:0]     seq_out,
    output logic [ssrf_pkg::OCC_W-1:0]     occupancy,
    output logic [ssrf_pkg::CNT_W-1:0]     pushes,
    output logic [ssrf_pkg::CNT_W-1:0]     pops,
    output logic [ssrf_pkg::CNT_W-1:0]     overflows,
    output logic [ssrf_pkg::CNT_W-1:0]     gaps
);

    localparam logic [ssrf_pkg::PTR_W-1:0] PTR_LAST =
        ssrf_pkg::PTR_W'(ssrf_pkg::RING_DEPTH - 1);

    // captured input word
    logic [ssrf_pkg::OP_W-1:0]  op_reg;
    logic [ssrf_pkg::SEQ_W-1:0] seq_reg;
    logic                       aok_reg;
    logic                       gok_reg;
    logic [ssrf_pkg::PAY_W-1:0] pay_reg;

    // queue state
    logic [ssrf_pkg::PTR_W-1:0] wp_reg, wp_next;
    logic [ssrf_pkg::PTR_W-1:0] rp_reg, rp_next;
    logic [ssrf_pkg::PTR_W-1:0] held_reg, held_next;
    logic [ssrf_pkg::SEQ_W-1:0] last_seq_reg, last_seq_next;
    logic [ssrf_pkg::CNT_W-1:0] push_reg, push_next;
    logic [ssrf_pkg::CNT_W-1:0] pop_reg, pop_next;
    logic [ssrf_pkg::CNT_W-1:0] ovf_reg, ovf_next;
    logic [ssrf_pkg::CNT_W-1:0] gap_reg, gap_next;

    // result held between execute and load
    ssrf_pkg::status_t pend_st_reg, pend_st_next;
    logic              pend_pop_reg, pend_pop_next;

    // output register
    logic                       out_valid_reg;
    ssrf_pkg::status_t          out_st_reg;
    logic [ssrf_pkg::PAY_W-1:0] out_pay_reg;
    logic [ssrf_pkg::SEQ_W-1:0] out_seq_reg;
    logic [ssrf_pkg::OCC_W-1:0] out_occ_reg;
    logic [ssrf_pkg::CNT_W-1:0] out_push_reg;
    logic [ssrf_pkg::CNT_W-1:0] out_pop_reg;
    logic [ssrf_pkg::CNT_W-1:0] out_ovf_reg;
    logic [ssrf_pkg::CNT_W-1:0] out_gap_reg;

    logic [ssrf_pkg::PTR_W-1:0] wp_adv;
    logic [ssrf_pkg::PTR_W-1:0] rp_adv;
    logic [ssrf_pkg::SEQ_W-1:0] seq_diff;

    assign wp_adv   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_adv   = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
    assign seq_diff = seq_reg - last_seq_reg;

    assign mem_waddr = wp_reg;
    assign mem_wdata = {pay_reg, seq_reg};
    assign mem_raddr = rp_reg;

    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        held_next     = held_reg;
        last_seq_next = last_seq_reg;
        push_next     = push_reg;
        pop_next      = pop_reg;
        ovf_next      = ovf_reg;
        gap_next      = gap_reg;
        pend_st_next  = pend_st_reg;
        pend_pop_next = pend_pop_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        if (cmd.execute)
        begin
            pend_st_next  = ssrf_pkg::ST_OK;
            pend_pop_next = 1'b0;
            unique case (op_reg)
                ssrf_pkg::OP_PUSH:
                begin
                    priority if (!aok_reg || !gok_reg)
                    begin
                        pend_st_next = ssrf_pkg::ST_INVALID;
                    end
                    else if (seq_reg == last_seq_reg)
                    begin
                        pend_st_next = ssrf_pkg::ST_DUPLICATE;
                    end
                    else
                    begin
                        // no gap counted while the last sequence number is zero, as before the first sample
                        if (last_seq_reg != '0 && seq_diff > ssrf_pkg::SEQ_W'(1))
                        begin
                            gap_next = gap_reg + (seq_diff - ssrf_pkg::SEQ_W'(1));
                        end
                        last_seq_next = seq_reg;
                        if (wp_adv == rp_reg)
                        begin
                            ovf_next     = ovf_reg + 1'b1;
                            pend_st_next = ssrf_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            wp_next   = wp_adv;
                            push_next = push_reg + 1'b1;
                            held_next = held_reg + 1'b1;
                        end
                    end
                end
                ssrf_pkg::OP_POP:
                begin
                    if (rp_reg == wp_reg)
                    begin
                        pend_st_next = ssrf_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        pend_pop_next = 1'b1;
                        rp_next       = rp_adv;
                        pop_next      = pop_reg + 1'b1;
                        if (held_reg != '0)
                        begin
                            held_next = held_reg - 1'b1;
                        end
                    end
                end
                ssrf_pkg::OP_CLEAR:
                begin
                    wp_next   = '0;
                    rp_next   = '0;
                    held_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // captured word, pending result and output fields carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            seq_reg <= seq_in;
            aok_reg <= accel_ok;
            gok_reg <= gyro_ok;
            pay_reg <= payload_in;
        end
        pend_st_reg  <= pend_st_next;
        pend_pop_reg <= pend_pop_next;
        if (cmd.load)
        begin
            out_st_reg   <= pend_st_reg;
            out_pay_reg  <= pend_pop_reg ? mem_rdata[ssrf_pkg::ENTRY_W-1:ssrf_pkg::SEQ_W] : '0;
            out_seq_reg  <= pend_pop_reg ? mem_rdata[ssrf_pkg::SEQ_W-1:0] : '0;
            out_occ_reg  <= ssrf_pkg::OCC_W'(held_reg);
            out_push_reg <= push_reg;
            out_pop_reg  <= pop_reg;
            out_ovf_reg  <= ovf_reg;
            out_gap_reg  <= gap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            held_reg      <= '0;
            last_seq_reg  <= '0;
            push_reg      <= '0;
            pop_reg       <= '0;
            ovf_reg       <= '0;
            gap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            held_reg     <= held_next;
            last_seq_reg <= last_seq_next;
            push_reg     <= push_next;
            pop_reg      <= pop_next;
            ovf_reg      <= ovf_next;
            gap_reg      <= gap_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dp_status.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign payload_out = out_pay_reg;
    assign seq_out     = out_seq_reg;
    assign occupancy   = out_occ_reg;
    assign pushes      = out_push_reg;
    assign pops        = out_pop_reg;
    assign overflows   = out_ovf_reg;
    assign gaps        = out_gap_reg;

endmodule

@@ sv/sequenced_sample_ring_fifo_top.sv @@
`timescale 1ns / 1ps

// sequenced sample ring fifo: a queue of sensor samples (32-bit sequence
// number plus 64-bit payload) held in a single-port-write, registered-read
// ring memory of RING_DEPTH entries, of which RING_DEPTH-1 are usable. each
// input word is a push, a pop, a clear or the spare code 3, which changes
// nothing; each gives exactly one result word carrying a status, the popped
// sample (zero unless a pop succeeds), the occupancy and the wrapping push,
// pop, overflow and gap counters. a push with either valid bit low, or whose
// sequence number repeats the last accepted one, is dropped; otherwise any
// forward gap from a nonzero last sequence number is counted and the sample
// is stored, or counted as an overflow when the ring is full. a word is
// captured at the accepting edge; the execute step updates the pointers and
// counters and reads or writes the ring, and the load step moves the result
// into the output register once the memory read data is back and the output
// register is free. the input reopens in the cycle after the load, even while
// that result still waits to be taken, but takes no new word while one is
// worked on. the ring contents come out of reset undefined; no clearing pass
// is needed because only written entries can be popped.
module sequenced_sample_ring_fifo_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ssrf_pkg::OP_W-1:0]     op,
    input  logic [ssrf_pkg::SEQ_W-1:0]    seq_in,
    input  logic                          accel_ok,
    input  logic                          gyro_ok,
    input  logic [ssrf_pkg::PAY_W-1:0]    payload_in,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ssrf_pkg::ST_W-1:0]     status,
    output logic [ssrf_pkg::PAY_W-1:0]    payload_out,
    output logic [ssrf_pkg::SEQ_W-1:0]    seq_out,
    output logic [ssrf_pkg::OCC_W-1:0]    occupancy,
    output logic [ssrf_pkg::CNT_W-1:0]    pushes,
    output logic [ssrf_pkg::CNT_W-1:0]    pops,
    output logic [ssrf_pkg::CNT_W-1:0]    overflows,
    output logic [ssrf_pkg::CNT_W-1:0]    gaps
);

`include "sequenced_sample_ring_fifo_top_defines.svh"

    // occupancy of a full ring
    localparam logic [ssrf_pkg::OCC_W-1:0] FULL_OCC = ssrf_pkg::OCC_W'(ssrf_pkg::RING_DEPTH - 1);

    ssrf_pkg::ctrl_cmd_t  cmd;
    ssrf_pkg::dp_status_t dp_status;
    logic                 busy;

    // ring memory signals
    logic                           mem_we;
    logic [ssrf_pkg::PTR_W-1:0]     mem_waddr;
    logic [ssrf_pkg::ENTRY_W-1:0]   mem_wdata;
    logic                           mem_re;
    logic [ssrf_pkg::PTR_W-1:0]     mem_raddr;
    logic [ssrf_pkg::ENTRY_W-1:0]   mem_rdata;

    // result-side conditions watched by the checks below
    logic                           res_empty;
    logic                           res_overflow;

    // sequencer: capture, execute, load
    ssrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // a new word is taken only while the sequencer is idle
    assign in_stall = busy;

    // pointers, counters, sequence tracking and the output register
    ssrf_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .dp_status   (dp_status),
        .op          (op),
        .seq_in      (seq_in),
        .accel_ok    (accel_ok),
        .gyro_ok     (gyro_ok),
        .payload_in  (payload_in),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .payload_out (payload_out),
        .seq_out     (seq_out),
        .occupancy   (occupancy),
        .pushes      (pushes),
        .pops        (pops),
        .overflows   (overflows),
        .gaps        (gaps)
    );

    // sample storage: payload in the upper bits, sequence number below
    ssrf_ram #(
        .W     (ssrf_pkg::ENTRY_W),
        .DEPTH (ssrf_pkg::RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_empty    = out_valid && (status == ssrf_pkg::ST_EMPTY);
    assign res_overflow = out_valid && (status == ssrf_pkg::ST_OVERFLOW);

    // an accepted word keeps the input side closed while it is worked on
    `SSRF_ASSERT_NEXT(a_accept_closes_input, in_valid && !in_stall, in_stall)

    // an empty pop carries no sample
    `SSRF_ASSERT_SAME(a_empty_no_sample, res_empty, payload_out == '0 && seq_out == '0)

    // an overflow is only reported with the ring at its usable capacity
    `SSRF_ASSERT_SAME(a_overflow_when_full, res_overflow, occupancy == FULL_OCC)

endmodule

@@ verif/tb_sequenced_sample_ring_fifo_top.sv @@
`timescale 1ns / 1ps

module tb_sequenced_sample_ring_fifo_top;

    // op code 3 has no meaning in the block: it must leave everything untouched
    localparam logic [ssrf_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_WORDS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    // margin for watching for stray result words once none are awaited
    localparam int SETTLE_CYCLES = 16;

    // one input word as offered to the block
    typedef struct {
        logic [ssrf_pkg::OP_W-1:0]  op;
        logic [ssrf_pkg::SEQ_W-1:0] seq;
        logic                       accel;
        logic                       gyro;
        logic [ssrf_pkg::PAY_W-1:0] pay;
    } sample_word_t;

    // one result word, expected or observed
    typedef struct {
        logic [ssrf_pkg::ST_W-1:0]  status;
        logic [ssrf_pkg::PAY_W-1:0] pay;
        logic [ssrf_pkg::SEQ_W-1:0] seq;
        logic [ssrf_pkg::OCC_W-1:0] occ;
        logic [ssrf_pkg::CNT_W-1:0] pushes;
        logic [ssrf_pkg::CNT_W-1:0] pops;
        logic [ssrf_pkg::CNT_W-1:0] overflows;
        logic [ssrf_pkg::CNT_W-1:0] gaps;
    } ring_result_t;

    // ring queue tracker: keeps its own copy of the ring, pointers and
    // counters, works out the result of each accepted word and checks the
    // result words against them in order
    class ring_scoreboard;
        logic [ssrf_pkg::PAY_W-1:0] ring_pay [ssrf_pkg::RING_DEPTH];
        logic [ssrf_pkg::SEQ_W-1:0] ring_seq [ssrf_pkg::RING_DEPTH];
        int                         wr_ptr;
        int                         rd_ptr;
        int                         held;
        logic [ssrf_pkg::SEQ_W-1:0] last_seq;
        logic [ssrf_pkg::CNT_W-1:0] push_total;
        logic [ssrf_pkg::CNT_W-1:0] pop_total;
        logic [ssrf_pkg::CNT_W-1:0] overflow_total;
        logic [ssrf_pkg::CNT_W-1:0] gap_total;
        ring_result_t               awaited [$];
        int                         errors;
        int                         checked;
        int                         status_seen [5];

        function new();
            wr_ptr         = 0;
            rd_ptr         = 0;
            held           = 0;
            last_seq       = '0;
            push_total     = '0;
            pop_total      = '0;
            overflow_total = '0;
            gap_total      = '0;
            errors         = 0;
            checked        = 0;
            status_seen    = '{default: 0};
        endfunction

        function void note_word(sample_word_t w);
            ring_result_t               r;
            logic [ssrf_pkg::SEQ_W-1:0] step;
            int                         nxt;
            r.status = ssrf_pkg::ST_OK;
            r.pay    = '0;
            r.seq    = '0;
            case (w.op)
                ssrf_pkg::OP_PUSH:
                begin
                    if (!w.accel || !w.gyro)
                    begin
                        r.status = ssrf_pkg::ST_INVALID;
                    end
                    else if (w.seq == last_seq)
                    begin
                        // also catches sequence zero while nothing is recorded yet
                        r.status = ssrf_pkg::ST_DUPLICATE;
                    end
                    else
                    begin
                        step = w.seq - last_seq;
                        if (last_seq != '0 && step > 1)
                            gap_total += step - 1;
                        last_seq = w.seq;
                        nxt = (wr_ptr + 1) % ssrf_pkg::RING_DEPTH;
                        if (nxt == rd_ptr)
                        begin
                            overflow_total += 1;
                            r.status = ssrf_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            ring_pay[wr_ptr] = w.pay;
                            ring_seq[wr_ptr] = w.seq;
                            wr_ptr = nxt;
                            push_total += 1;
                            held++;
                        end
                    end
                end
                ssrf_pkg::OP_POP:
                begin
                    if (rd_ptr == wr_ptr)
                    begin
                        r.status = ssrf_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        r.pay  = ring_pay[rd_ptr];
                        r.seq  = ring_seq[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % ssrf_pkg::RING_DEPTH;
                        pop_total += 1;
                        if (held != 0)
                            held--;
                    end
                end
                ssrf_pkg::OP_CLEAR:
                begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                    held   = 0;
                end
                default:
                begin
                end
            endcase
            r.occ       = held[ssrf_pkg::OCC_W-1:0];
            r.pushes    = push_total;
            r.pops      = pop_total;
            r.overflows = overflow_total;
            r.gaps      = gap_total;
            awaited.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(ring_result_t got);
            ring_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result word with nothing expected, status %0h",
                         $time, got.status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.status < 5)
                status_seen[want.status]++;
            compare("status", want.status, got.status);
            compare("payload_out", want.pay, got.pay);
            compare("seq_out", want.seq, got.seq);
            compare("occupancy", want.occ, got.occ);
            compare("pushes", want.pushes, got.pushes);
            compare("pops", want.pops, got.pops);
            compare("overflows", want.overflows, got.overflows);
            compare("gaps", want.gaps, got.gaps);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [ssrf_pkg::OP_W-1:0]  op;
    logic [ssrf_pkg::SEQ_W-1:0] seq_in;
    logic                       accel_ok;
    logic                       gyro_ok;
    logic [ssrf_pkg::PAY_W-1:0] payload_in;
    logic                       out_valid;
    logic                       out_stall;
    logic [ssrf_pkg::ST_W-1:0]  status;
    logic [ssrf_pkg::PAY_W-1:0] payload_out;
    logic [ssrf_pkg::SEQ_W-1:0] seq_out;
    logic [ssrf_pkg::OCC_W-1:0] occupancy;
    logic [ssrf_pkg::CNT_W-1:0] pushes;
    logic [ssrf_pkg::CNT_W-1:0] pops;
    logic [ssrf_pkg::CNT_W-1:0] overflows;
    logic [ssrf_pkg::CNT_W-1:0] gaps;

    ring_scoreboard sb = new();
    int             words_sent  = 0;
    int             cycle_count = 0;
    // while set, the matching side runs without idling
    bit             src_steady  = 1'b0;
    bit             sink_steady = 1'b0;

    sequenced_sample_ring_fifo_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .seq_in      (seq_in),
        .accel_ok    (accel_ok),
        .gyro_ok     (gyro_ok),
        .payload_in  (payload_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .payload_out (payload_out),
        .seq_out     (seq_out),
        .occupancy   (occupancy),
        .pushes      (pushes),
        .pops        (pops),
        .overflows   (overflows),
        .gaps        (gaps)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic sample_word_t make_word(logic [ssrf_pkg::OP_W-1:0] o,
                                               logic [ssrf_pkg::SEQ_W-1:0] s,
                                               logic a, logic g,
                                               logic [ssrf_pkg::PAY_W-1:0] p);
        sample_word_t w;
        w.op    = o;
        w.seq   = s;
        w.accel = a;
        w.gyro  = g;
        w.pay   = p;
        return w;
    endfunction

    // a push built around the last recorded sequence number: mostly the
    // next one in order, with gaps, repeats, jumps and the 32-bit wrap mixed in
    function automatic sample_word_t random_push();
        sample_word_t w;
        int           r;
        r       = $urandom_range(0, 99);
        w.op    = ssrf_pkg::OP_PUSH;
        if (r < 70)
            w.seq = sb.last_seq + 1;
        else if (r < 80)
            w.seq = sb.last_seq + $urandom_range(2, 20);
        else if (r < 85)
            w.seq = sb.last_seq;
        else if (r < 92)
            w.seq = $urandom;
        else
            w.seq = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        if ($urandom_range(0, 9) != 0)
            {w.accel, w.gyro} = 2'b11;
        else
            {w.accel, w.gyro} = 2'($urandom_range(0, 2));
        r = $urandom_range(0, 19);
        if (r == 0)
            w.pay = '0;
        else if (r == 1)
            w.pay = '1;
        else
            w.pay = {$urandom, $urandom};
        return w;
    endfunction

    // push_pct of the words are pushes; ctrl_pct are clears or the spare code
    function automatic sample_word_t random_word(int push_pct, int ctrl_pct);
        sample_word_t w;
        int           r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return random_push();
        // the fields that a pop ignores carry noise
        w = make_word(ssrf_pkg::OP_POP, $urandom, 1'($urandom), 1'($urandom),
                      {$urandom, $urandom});
        if (r >= 100 - ctrl_pct)
            w.op = r[0] ? OP_SPARE : ssrf_pkg::OP_CLEAR;
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(sample_word_t w);
        int gap;
        if ($urandom_range(0, 19) == 0)
            src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= w.op;
        seq_in     <= w.seq;
        accel_ok   <= w.accel;
        gyro_ok    <= w.gyro;
        payload_in <= w.pay;
        // hold the word until the block takes it
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    // result side: take a word whenever valid and not stalled, then stall
    // for a drawn number of cycles before taking the next one
    initial
    begin
        ring_result_t seen;
        int           hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                seen.status    = status;
                seen.pay       = payload_out;
                seen.seq       = seq_out;
                seen.occ       = occupancy;
                seen.pushes    = pushes;
                seen.pops      = pops;
                seen.overflows = overflows;
                seen.gaps      = gaps;
                sb.check_result(seen);
                if ($urandom_range(0, 19) == 0)
                    sink_steady = !sink_steady;
                hold = sink_steady ? 0 : $urandom_range(0, 4);
            end
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on the whole run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still awaited",
                 cycle_count, sb.awaited.size());
        $display("sequenced_sample_ring_fifo_top verification failed");
        $finish;
    end

    initial
    begin
        int goal;
        int kind;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = ssrf_pkg::OP_PUSH;
        seq_in     = '0;
        accel_ok   = 1'b0;
        gyro_ok    = 1'b0;
        payload_in = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening: empty pop, the first-sample rules, invalid
        // pushes, gap counting across the 32-bit wrap, clear and the spare op
        send_word(make_word(ssrf_pkg::OP_POP, '1, 1'b1, 1'b1, '1));
        // sequence zero while nothing recorded counts as a repeat
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd0, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF));
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd7, 1'b0, 1'b1, '1));
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd7, 1'b1, 1'b0, '1));
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd7, 1'b0, 1'b0, '1));
        // first stored sample: no gap counted
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd5, 1'b1, 1'b1, '1));
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd5, 1'b1, 1'b1, 64'h5555_5555_5555_5555));
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd6, 1'b1, 1'b1, '0));
        // three missing
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd10, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA));
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b1, 1'b1,
                            64'h5555_5555_5555_5555));
        // wraps to zero in order, then restarts the first-sample rule
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd0, 1'b1, 1'b1, 64'h8000_0000_0000_0001));
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd3, 1'b1, 1'b1, 64'hFEDC_BA98_7654_3210));
        send_word(make_word(ssrf_pkg::OP_POP, 32'd0, 1'b0, 1'b0, '0));
        send_word(make_word(ssrf_pkg::OP_POP, '1, 1'b0, 1'b1, '1));
        send_word(make_word(OP_SPARE, 32'd9, 1'b1, 1'b1, '1));
        send_word(make_word(ssrf_pkg::OP_CLEAR, 32'd0, 1'b1, 1'b1, '0));
        send_word(make_word(ssrf_pkg::OP_POP, 32'd0, 1'b1, 1'b1, '0));
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd4, 1'b1, 1'b1, 64'h0000_0001_0000_0001));
        // going backwards counts as a huge forward gap that wraps the counter
        send_word(make_word(ssrf_pkg::OP_PUSH, 32'd2, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF));
        send_word(make_word(ssrf_pkg::OP_POP, 32'd0, 1'b1, 1'b1, '0));
        send_word(make_word(ssrf_pkg::OP_POP, 32'd0, 1'b1, 1'b1, '0));
        send_word(make_word(ssrf_pkg::OP_POP, 32'd0, 1'b1, 1'b1, '0));

        // random part in episodes: fill the ring into overflow, drain it
        // past empty, or a loose mix with clears and the spare op
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal)
        begin
            kind = $urandom_range(0, 3);
            case (kind)
                0:
                begin
                    while (sb.held < ssrf_pkg::RING_DEPTH - 1 && words_sent < goal)
                        send_word(random_word(90, 0));
                    repeat ($urandom_range(2, 8)) send_word(random_push());
                end
                1:
                begin
                    while (sb.held > 0 && words_sent < goal)
                        send_word(random_word(10, 0));
                    repeat ($urandom_range(1, 4))
                        send_word(make_word(ssrf_pkg::OP_POP, $urandom, 1'($urandom),
                                            1'($urandom), {$urandom, $urandom}));
                end
                default:
                begin
                    repeat ($urandom_range(20, 60)) send_word(random_word(45, 4));
                end
            endcase
        end
        in_valid <= 1'b0;

        // let every expected word arrive, then watch for strays
        while (sb.awaited.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d words: %0d ok, %0d invalid, %0d repeat, %0d overflow, %0d empty",
                 words_sent, sb.status_seen[ssrf_pkg::ST_OK],
                 sb.status_seen[ssrf_pkg::ST_INVALID],
                 sb.status_seen[ssrf_pkg::ST_DUPLICATE],
                 sb.status_seen[ssrf_pkg::ST_OVERFLOW],
                 sb.status_seen[ssrf_pkg::ST_EMPTY]);
        $display("results checked %0d, final pushes %0d pops %0d overflows %0d gaps %0h",
                 sb.checked, sb.push_total, sb.pop_total, sb.overflow_total, sb.gap_total);
        if (sb.errors == 0)
            $display("sequenced_sample_ring_fifo_top verification clean");
        else
            $display("sequenced_sample_ring_fifo_top verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/ssrf_pkg.sv
sv/ssrf_ram.sv
sv/ssrf_ctrl.sv
sv/ssrf_dpath.sv
sv/sequenced_sample_ring_fifo_top.sv
verif/tb_sequenced_sample_ring_fifo_top.sv
